// File: rtl/lrast_pkg.sv
// Shared types and constants for the saturating line rasterizer.
// No dependencies; every other file but lrast_ram imports this package.
package lrast_pkg;

    // Default sizes handed to the top-level parameters
    localparam int MAX_WIDTH_DEF  = 512;
    localparam int MAX_HEIGHT_DEF = 512;
    localparam int COORD_BITS_DEF = 12;

    // Command codes carried in s_tuser
    localparam int CMD_BITS = 2;
    localparam logic [CMD_BITS-1:0] CMD_DRAW  = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_READ  = 2'd2;

    // Configuration registers
    localparam int CFG_BITS       = 10;
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HEIGHT = 1'd1;
    localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 10'd330;
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 10'd410;

    // Pixel and count ranges
    localparam int PIX_BITS   = 8;
    localparam logic [PIX_BITS-1:0] PIX_MAX = 8'd255;
    localparam int COUNT_BITS = 13;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = 13'd8191;

    // Result payload: read_value, pixels_written, zero pad to whole bytes
    localparam int OUT_FIELD_BITS = PIX_BITS + COUNT_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS   = OUT_DATA_BITS - OUT_FIELD_BITS;

    // Control into the line walker
    typedef struct packed {
        logic start;
        logic is_read;
    } walk_ctl_t;

    // Qualifiers of the point the walker presents this cycle
    typedef struct packed {
        logic valid;
        logic in_bounds;
        logic is_read;
    } pt_ctl_t;

    // Control into the pixel pipeline
    typedef struct packed {
        logic clear_start;
        logic op_start;
    } pipe_ctl_t;

    // Status out of the pixel pipeline
    typedef struct packed {
        logic busy;
        logic clear_busy;
    } pipe_stat_t;

endpackage

// File: rtl/saturating_line_rasterizer_unit.sv
// Top level of the saturating line rasterizer: stream ports, size registers,
// command sequencing and result register. Depends on lrast_pkg, lrast_walker, lrast_pixel_pipe.
//
// Takes one command at a time. A draw posts its result once the walker has handed
// every point on the line (endpoints included), one point per cycle, to a three-stage
// read-modify-write pipe on the frame store (one write port, one read port), which
// must drain before the result register loads. A read walks its single start point
// through the same pipe. A clear sweeps the store one entry per cycle and posts its
// result after the sweep ends. s_tready rises again as a result is posted, so the next
// command is taken while a result waits in the output register. The same sweep runs
// after reset, and s_tready first rises once it is done. Configuration writes are
// always taken and belong to idle periods.
module saturating_line_rasterizer_unit import lrast_pkg::*; #(
    parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT    = MAX_HEIGHT_DEF,
    parameter int COORD_BITS    = COORD_BITS_DEF,
    localparam int IN_DATA_BITS = ((4 * COORD_BITS + PIX_BITS + 7) / 8) * 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // s_tdata: start_x, start_y, end_x, end_y, intensity, zero pad
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_DATA_BITS-1:0]   s_tdata,
    // s_tuser: cmd
    input  logic [CMD_BITS-1:0]       s_tuser,
    // m_tdata: read_value, pixels_written, zero pad
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_DATA_BITS-1:0]  m_tdata,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]       cfg_data
);

    localparam int DIM_W_BITS = $clog2(MAX_WIDTH + 1);
    localparam int DIM_H_BITS = $clog2(MAX_HEIGHT + 1);

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_WALK  = 3'd2;
    localparam logic [2:0] ST_CLEAR = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] state_reg, state_next;

    logic [CFG_BITS-1:0]   width_reg, height_reg;
    logic [DIM_W_BITS-1:0] eff_w;
    logic [DIM_H_BITS-1:0] eff_h;

    logic [CMD_BITS-1:0] cmd_reg;
    logic [PIX_BITS-1:0] intensity_reg;

    logic                         accept;
    logic signed [COORD_BITS-1:0] in_start_x, in_start_y, in_end_x, in_end_y;

    walk_ctl_t                    walk_ctl;
    logic                         walk_busy;
    pt_ctl_t                      pt;
    logic signed [COORD_BITS-1:0] pt_x, pt_y;
    logic [COUNT_BITS-1:0]        walk_count;

    pipe_ctl_t           pipe_ctl;
    pipe_stat_t          pipe_stat;
    logic [PIX_BITS-1:0] pipe_read_value;

    logic                     out_valid_reg, out_load;
    logic [OUT_DATA_BITS-1:0] out_data_reg;
    logic [PIX_BITS-1:0]      res_read;
    logic [COUNT_BITS-1:0]    res_count;

    // Request unpacking
    assign accept     = s_tvalid && s_tready;
    assign in_start_x = s_tdata[0*COORD_BITS +: COORD_BITS];
    assign in_start_y = s_tdata[1*COORD_BITS +: COORD_BITS];
    assign in_end_x   = s_tdata[2*COORD_BITS +: COORD_BITS];
    assign in_end_y   = s_tdata[3*COORD_BITS +: COORD_BITS];

    // Size registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Active size, capped at the store dimensions
    assign eff_w = (32'(width_reg) > 32'(MAX_WIDTH)) ? DIM_W_BITS'(MAX_WIDTH)
                                                     : DIM_W_BITS'(width_reg);
    assign eff_h = (32'(height_reg) > 32'(MAX_HEIGHT)) ? DIM_H_BITS'(MAX_HEIGHT)
                                                       : DIM_H_BITS'(height_reg);

    // Command latch
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg       <= s_tuser;
            intensity_reg <= s_tdata[4*COORD_BITS +: PIX_BITS];
        end
    end

    // Launch controls
    assign walk_ctl.start        = accept && ((s_tuser == CMD_DRAW) || (s_tuser == CMD_READ));
    assign walk_ctl.is_read      = (s_tuser == CMD_READ);
    assign pipe_ctl.clear_start  = accept && (s_tuser == CMD_CLEAR);
    assign pipe_ctl.op_start     = walk_ctl.start;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (!pipe_stat.clear_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (s_tuser)
                        CMD_DRAW:  state_next = ST_WALK;
                        CMD_READ:  state_next = ST_WALK;
                        CMD_CLEAR: state_next = ST_CLEAR;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_WALK:
            begin
                if (!walk_busy && !pipe_stat.busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_CLEAR:
            begin
                if (!pipe_stat.clear_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    // Result register
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);
    assign res_read  = (cmd_reg == CMD_READ) ? pipe_read_value : '0;
    assign res_count = (cmd_reg == CMD_DRAW) ? walk_count : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= {{OUT_PAD_BITS{1'b0}}, res_count, res_read};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    lrast_walker #(
        .COORD_BITS (COORD_BITS),
        .DIM_W_BITS (DIM_W_BITS),
        .DIM_H_BITS (DIM_H_BITS)
    ) u_walker (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (walk_ctl),
        .start_x (in_start_x),
        .start_y (in_start_y),
        .end_x   (in_end_x),
        .end_y   (in_end_y),
        .eff_w   (eff_w),
        .eff_h   (eff_h),
        .busy    (walk_busy),
        .pt      (pt),
        .pt_x    (pt_x),
        .pt_y    (pt_y),
        .count   (walk_count)
    );

    lrast_pixel_pipe #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COORD_BITS (COORD_BITS),
        .DIM_W_BITS (DIM_W_BITS)
    ) u_pixel_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (pipe_ctl),
        .pt         (pt),
        .pt_x       (pt_x),
        .pt_y       (pt_y),
        .eff_w      (eff_w),
        .intensity  (intensity_reg),
        .stat       (pipe_stat),
        .read_value (pipe_read_value)
    );

endmodule

// File: rtl/lrast_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lrast_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/lrast_walker.sv
// Bresenham point generator: one line point per cycle, bounds test, point count.
// Depends on lrast_pkg.
module lrast_walker import lrast_pkg::*; #(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int DIM_W_BITS  = 10,
    parameter int DIM_H_BITS  = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  walk_ctl_t                    ctl,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    input  logic [DIM_W_BITS-1:0]        eff_w,
    input  logic [DIM_H_BITS-1:0]        eff_h,
    output logic                         busy,
    output pt_ctl_t                      pt,
    output logic signed [COORD_BITS-1:0] pt_x,
    output logic signed [COORD_BITS-1:0] pt_y,
    output logic [COUNT_BITS-1:0]        count
);

    // Error term width: deltas need one bit more than coords, error one more
    localparam int EB = COORD_BITS + 2;

    logic signed [COORD_BITS-1:0] x_reg, y_reg, xe_reg, ye_reg;
    logic signed [EB-1:0]         dx_reg, dy_reg, err_reg;
    logic                         sx_neg_reg, sy_neg_reg;
    logic                         busy_reg, read_reg;
    logic [COUNT_BITS-1:0]        count_reg;

    logic signed [COORD_BITS-1:0] end_x_sel, end_y_sel;
    logic signed [EB-1:0]         diff_x, diff_y, abs_dx, abs_dy;
    logic signed [EB:0]           e2;
    logic                         step_x, step_y, is_last, in_bounds;
    logic signed [EB-1:0]         err_next;

    // Setup: a read walks the single start point
    always_comb
    begin
        end_x_sel = ctl.is_read ? start_x : end_x;
        end_y_sel = ctl.is_read ? start_y : end_y;
        diff_x    = EB'(end_x_sel) - EB'(start_x);
        diff_y    = EB'(end_y_sel) - EB'(start_y);
        abs_dx    = diff_x[EB-1] ? -diff_x : diff_x;
        abs_dy    = diff_y[EB-1] ? -diff_y : diff_y;
    end

    // One Bresenham step
    always_comb
    begin
        e2       = {err_reg, 1'b0};
        step_x   = (e2 >= (EB+1)'(dy_reg));
        step_y   = (e2 <= (EB+1)'(dx_reg));
        err_next = err_reg + (step_x ? dy_reg : EB'(0)) + (step_y ? dx_reg : EB'(0));
        is_last  = (x_reg == xe_reg) && (y_reg == ye_reg);
    end

    // Clip against the active frame size
    assign in_bounds = !x_reg[COORD_BITS-1] && !y_reg[COORD_BITS-1]
                    && (32'($unsigned(x_reg)) < 32'(eff_w))
                    && (32'($unsigned(y_reg)) < 32'(eff_h));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg      <= '0;
            y_reg      <= '0;
            xe_reg     <= '0;
            ye_reg     <= '0;
            dx_reg     <= '0;
            dy_reg     <= '0;
            err_reg    <= '0;
            sx_neg_reg <= 1'b0;
            sy_neg_reg <= 1'b0;
            busy_reg   <= 1'b0;
            read_reg   <= 1'b0;
            count_reg  <= '0;
        end
        else if (ctl.start)
        begin
            x_reg      <= start_x;
            y_reg      <= start_y;
            xe_reg     <= end_x_sel;
            ye_reg     <= end_y_sel;
            dx_reg     <= abs_dx;
            dy_reg     <= -abs_dy;
            err_reg    <= abs_dx - abs_dy;
            sx_neg_reg <= !(start_x < end_x_sel);
            sy_neg_reg <= !(start_y < end_y_sel);
            busy_reg   <= 1'b1;
            read_reg   <= ctl.is_read;
            count_reg  <= '0;
        end
        else if (busy_reg)
        begin
            // Saturating count of in-bounds points
            if (in_bounds && (count_reg != COUNT_MAX))
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (is_last)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                err_reg <= err_next;
                if (step_x)
                begin
                    x_reg <= sx_neg_reg ? x_reg - 1'b1 : x_reg + 1'b1;
                end
                if (step_y)
                begin
                    y_reg <= sy_neg_reg ? y_reg - 1'b1 : y_reg + 1'b1;
                end
            end
        end
    end

    assign busy         = busy_reg;
    assign pt.valid     = busy_reg;
    assign pt.in_bounds = in_bounds;
    assign pt.is_read   = read_reg;
    assign pt_x         = x_reg;
    assign pt_y         = y_reg;
    assign count        = count_reg;

endmodule

// File: rtl/lrast_pixel_pipe.sv
// Pixel pipeline around the frame store: address, read, saturating add, write back;
// also the zeroing sweep. Depends on lrast_pkg and lrast_ram.
module lrast_pixel_pipe import lrast_pkg::*; #(
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int DIM_W_BITS  = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pipe_ctl_t                    ctl,
    input  pt_ctl_t                      pt,
    input  logic signed [COORD_BITS-1:0] pt_x,
    input  logic signed [COORD_BITS-1:0] pt_y,
    input  logic [DIM_W_BITS-1:0]        eff_w,
    input  logic [PIX_BITS-1:0]          intensity,
    output pipe_stat_t                   stat,
    output logic [PIX_BITS-1:0]          read_value
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XB    = $clog2(MAX_WIDTH);
    localparam int YB    = $clog2(MAX_HEIGHT);

    // Stage 1: in-bounds point, coordinates as indexes
    logic          v1_reg, r1_reg;
    logic [XB-1:0] xi1_reg;
    logic [YB-1:0] yi1_reg;
    // Stage 2: linear address, read issued
    logic          v2_reg, r2_reg;
    logic [AW-1:0] addr2_reg;
    // Stage 3: read data back, write issued
    logic          v3_reg, r3_reg;
    logic [AW-1:0] addr3_reg;

    logic [AW-1:0]       addr_next;
    logic [PIX_BITS:0]   sum;
    logic [PIX_BITS-1:0] sat_pix;
    logic [PIX_BITS-1:0] rd_data;
    logic [PIX_BITS-1:0] rv_reg;

    // Zeroing sweep; starts right out of reset
    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;

    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [PIX_BITS-1:0] wr_data;

    // Row-major address
    assign addr_next = AW'(yi1_reg) * AW'(eff_w) + AW'(xi1_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= pt.valid && pt.in_bounds;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Payload of the stages
    always_ff @(posedge clk)
    begin
        r1_reg    <= pt.is_read;
        xi1_reg   <= XB'($unsigned(pt_x));
        yi1_reg   <= YB'($unsigned(pt_y));
        r2_reg    <= r1_reg;
        addr2_reg <= addr_next;
        r3_reg    <= r2_reg;
        addr3_reg <= addr2_reg;
    end

    // Saturating add. Line points are all distinct, so a write never hits
    // the entry being read in the same cycle and no forwarding is needed.
    assign sum     = {1'b0, rd_data} + {1'b0, intensity};
    assign sat_pix = sum[PIX_BITS] ? PIX_MAX : sum[PIX_BITS-1:0];

    // Read result, zero unless an in-bounds read point came through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg <= '0;
        end
        else if (ctl.op_start)
        begin
            rv_reg <= '0;
        end
        else if (v3_reg && r3_reg)
        begin
            rv_reg <= rd_data;
        end
    end

    // Clear sweep, one entry per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (ctl.clear_start)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
            else
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    // Write port shared by the sweep and the pixel update
    assign wr_en   = clr_busy_reg || (v3_reg && !r3_reg);
    assign wr_addr = clr_busy_reg ? clr_addr_reg : addr3_reg;
    assign wr_data = clr_busy_reg ? '0 : sat_pix;

    lrast_ram #(
        .WIDTH (PIX_BITS),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (v2_reg),
        .rd_addr (addr2_reg),
        .rd_data (rd_data)
    );

    assign stat.busy       = v1_reg || v2_reg || v3_reg;
    assign stat.clear_busy = clr_busy_reg;
    assign read_value      = rv_reg;

endmodule

// File: rtl/lrast_checker.sv
// Port-level checks for the saturating line rasterizer, bound to the top level.
// Depends on lrast_pkg and saturating_line_rasterizer_unit.
module lrast_checker import lrast_pkg::*; (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     s_tvalid,
    input logic                     s_tready,
    input logic                     m_tvalid,
    input logic                     m_tready,
    input logic [OUT_DATA_BITS-1:0] m_tdata
);

    // One request at a time: taking one drops ready
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while a command is in progress");

    // A stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // A result carries a read value or a count, never both
    a_field_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[PIX_BITS-1:0] == '0)
                   || (m_tdata[PIX_BITS +: COUNT_BITS] == '0)))
        else $error("read value and pixel count both nonzero");

    // Posting a result returns the block to idle
    a_post_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> s_tready)
        else $error("result posted without returning to idle");

endmodule

bind saturating_line_rasterizer_unit lrast_checker u_lrast_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: verif/saturating_line_rasterizer_unit_tb.sv
// Self-checking bench for saturating_line_rasterizer_unit: streams draw, clear, read and
// unused-code requests, predicts every result from a local pixel store and checks each result field.
// Depends on lrast_pkg and the RTL of the unit; reads no files.
module saturating_line_rasterizer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lrast_pkg::*;

    localparam int COORD_W          = COORD_BITS_DEF;
    localparam int IN_DATA_W        = ((4 * COORD_W + PIX_BITS + 7) / 8) * 8;
    localparam int STORE_DEPTH      = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
    localparam int COORD_LO         = -(1 << (COORD_W - 1));
    localparam int COORD_HI         = (1 << (COORD_W - 1)) - 1;
    localparam int WATCHDOG_LIMIT   = 1_100_000;
    localparam int DRAIN_CYCLES     = 30;
    localparam int NUM_PHASES       = 9;
    localparam int ITEMS_PER_PHASE  = 114;
    localparam int MAX_REPORTS      = 10;
    localparam int SPOT_KEEP        = 24;
    localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [CMD_BITS-1:0]       cmd;
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic [PIX_BITS-1:0]       intensity;
    } rast_cmd_t;

    // Same bit order as m_tdata: read_value in the low byte
    typedef struct packed {
        logic [COUNT_BITS-1:0] pixels_written;
        logic [PIX_BITS-1:0]   read_value;
    } rast_result_t;

    typedef struct {
        int x;
        int y;
    } spot_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [IN_DATA_W-1:0]      s_tdata = '0;
    logic [CMD_BITS-1:0]       s_tuser = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0]  m_tdata;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0]       cfg_data = '0;

    // Predictor state: pixel store and active size
    bit   [PIX_BITS-1:0] pixel_mem [STORE_DEPTH];
    logic [CFG_BITS-1:0] cur_width = WIDTH_RESET;
    logic [CFG_BITS-1:0] cur_height = HEIGHT_RESET;

    rast_cmd_t    pending_cmds [$];
    rast_result_t results_due [$];
    spot_t        recent_spots [$];
    rast_cmd_t    on_bus;

    bit in_fire = 1'b0;
    bit no_idle = 1'b0;
    int burst_timer = 0;
    int send_gap = 0;
    int recv_stall = 0;
    int issued_cnt = 0;
    int accepted_cnt = 0;
    int result_cnt = 0;
    int stall_cycles = 0;
    int fail_count = 0;

    // Run statistics
    int draws_seen = 0;
    int reads_seen = 0;
    int reads_nonzero = 0;
    int reads_full = 0;
    int clears_seen = 0;
    int unused_seen = 0;
    int pixels_plotted = 0;
    int size_settings = 0;

    saturating_line_rasterizer_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int act_width();
        int w;
        w = cur_width;
        return (w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w;
    endfunction

    function automatic int act_height();
        int h;
        h = cur_height;
        return (h > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : h;
    endfunction

    function automatic bit in_area(int x, int y);
        return x >= 0 && y >= 0 && x < act_width() && y < act_height();
    endfunction

    // Apply one request to the local store and return the result it must produce
    function automatic rast_result_t rasterize(rast_cmd_t c);
        rast_result_t res;
        int x, y, x1, y1, dx, dy, sx, sy, err, e2, addr, sum;
        bit done;
        res = '0;
        x = c.x0;
        y = c.y0;
        x1 = c.x1;
        y1 = c.y1;
        case (c.cmd)
            CMD_DRAW:
            begin
                dx = (x1 > x) ? x1 - x : x - x1;
                dy = (y1 > y) ? y - y1 : y1 - y;
                sx = (x < x1) ? 1 : -1;
                sy = (y < y1) ? 1 : -1;
                err = dx + dy;
                done = 1'b0;
                while (!done)
                begin
                    if (in_area(x, y))
                    begin
                        addr = y * act_width() + x;
                        sum = pixel_mem[addr] + c.intensity;
                        pixel_mem[addr] = (sum > int'(PIX_MAX)) ? PIX_MAX : PIX_BITS'(sum);
                        if (res.pixels_written != COUNT_MAX)
                            res.pixels_written++;
                        pixels_plotted++;
                    end
                    if (x == x1 && y == y1)
                        done = 1'b1;
                    else
                    begin
                        e2 = 2 * err;
                        if (e2 >= dy)
                        begin
                            err += dy;
                            x += sx;
                        end
                        if (e2 <= dx)
                        begin
                            err += dx;
                            y += sy;
                        end
                    end
                end
                draws_seen++;
            end
            CMD_CLEAR:
            begin
                foreach (pixel_mem[i])
                    pixel_mem[i] = '0;
                clears_seen++;
            end
            CMD_READ:
            begin
                if (in_area(x, y))
                    res.read_value = pixel_mem[y * act_width() + x];
                reads_seen++;
                if (res.read_value != 0)
                    reads_nonzero++;
                if (res.read_value == PIX_MAX)
                    reads_full++;
            end
            default:
                unused_seen++;
        endcase
        return res;
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] %s", $realtime, msg);
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic rast_cmd_t mk(logic [CMD_BITS-1:0] cmd, int x0, int y0, int x1, int y1,
                                     int intensity);
        rast_cmd_t c;
        c.cmd = cmd;
        c.x0 = COORD_W'(x0);
        c.y0 = COORD_W'(y0);
        c.x1 = COORD_W'(x1);
        c.y1 = COORD_W'(y1);
        c.intensity = PIX_BITS'(intensity);
        return c;
    endfunction

    function automatic int full_coord();
        return int'($urandom_range(0, COORD_HI - COORD_LO)) + COORD_LO;
    endfunction

    // Coordinate around the active area, a little outside on both ends
    function automatic int near_coord(int span);
        return int'($urandom_range(0, span + 39)) - 20;
    endfunction

    function automatic int clamp_coord(int v);
        if (v < COORD_LO)
            return COORD_LO;
        if (v > COORD_HI)
            return COORD_HI;
        return v;
    endfunction

    function automatic int rand_intensity();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 255;
        if (r < 30)
            return 0;
        if (r < 50)
            return $urandom_range(1, 4);
        return $urandom_range(0, 255);
    endfunction

    function automatic void keep_spot(int x, int y);
        spot_t s;
        s.x = x;
        s.y = y;
        recent_spots.push_back(s);
        if (recent_spots.size() > SPOT_KEEP)
            void'(recent_spots.pop_front());
    endfunction

    // Mostly short draws near the active area, reads of recently drawn spots,
    // a few long lines across the whole coordinate range and some unused codes
    function automatic rast_cmd_t rand_item(int span_w, int span_h);
        int pick, kind, x0, y0, x1, y1, dx, dy;
        spot_t s;
        pick = $urandom_range(0, 99);
        x0 = near_coord(span_w);
        y0 = near_coord(span_h);
        if ($urandom_range(0, 4) == 0)
        begin
            x0 = full_coord();
            y0 = full_coord();
        end
        x1 = full_coord();
        y1 = full_coord();
        if (pick < 5)
            return mk(CMD_UNUSED, x0, y0, x1, y1, rand_intensity());
        if (pick < 35)
        begin
            if (recent_spots.size() > 0 && $urandom_range(0, 9) < 6)
            begin
                s = recent_spots[$urandom_range(0, recent_spots.size() - 1)];
                x0 = s.x;
                y0 = s.y;
            end
            return mk(CMD_READ, x0, y0, x1, y1, rand_intensity());
        end
        kind = $urandom_range(0, 99);
        if (kind < 4)
        begin
            x0 = full_coord();
            y0 = full_coord();
        end
        else
        begin
            dx = int'($urandom_range(0, 48)) - 24;
            dy = int'($urandom_range(0, 48)) - 24;
            if (kind < 14)
                dx = 0;
            else if (kind < 24)
                dy = 0;
            else if (kind < 30)
            begin
                dx = 0;
                dy = 0;
            end
            x1 = clamp_coord(x0 + dx);
            y1 = clamp_coord(y0 + dy);
        end
        keep_spot(x0, y0);
        keep_spot(x1, y1);
        return mk(CMD_DRAW, x0, y0, x1, y1, rand_intensity());
    endfunction

    function automatic void queue_item(rast_cmd_t c);
        pending_cmds.push_back(c);
        issued_cnt++;
    endfunction

    task automatic cfg_write(logic [CFG_INDEX_BITS-1:0] index, int value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= CFG_BITS'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic set_size(int w, int h);
        cfg_write(REG_WIDTH, w);
        cfg_write(REG_HEIGHT, h);
        @(negedge clk);
        cfg_valid <= 1'b0;
        size_settings++;
    endtask

    // Block until every request is taken and every result has come back
    task automatic wait_drained();
        do
            @(posedge clk);
        while (!(accepted_cnt == issued_cnt && results_due.size() == 0));
    endtask

    // Request and result side handshakes, changed on the falling edge
    always @(negedge clk)
    begin : drive_blk
        if (burst_timer == 0)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            burst_timer = $urandom_range(50, 400);
        end
        else
            burst_timer--;

        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || in_fire)
        begin
            if (send_gap > 0)
            begin
                s_tvalid <= 1'b0;
                send_gap--;
            end
            else if (pending_cmds.size() > 0)
            begin
                on_bus = pending_cmds.pop_front();
                s_tuser <= on_bus.cmd;
                s_tdata <= IN_DATA_W'({on_bus.intensity, on_bus.y1, on_bus.x1,
                                       on_bus.y0, on_bus.x0});
                s_tvalid <= 1'b1;
                send_gap = pick_gap();
            end
            else
                s_tvalid <= 1'b0;
        end

        if (recv_stall > 0)
        begin
            m_tready <= 1'b0;
            recv_stall--;
        end
        else
        begin
            m_tready <= 1'b1;
            recv_stall = pick_gap();
        end
    end

    // Sample handshakes on the rising edge: predict, check, watch for hangs
    always @(posedge clk)
    begin : monitor_blk
        rast_result_t got;
        rast_result_t want;
        bit out_fire;
        bit cfg_fire;
        in_fire = s_tvalid && s_tready;
        out_fire = m_tvalid && m_tready;
        cfg_fire = cfg_valid && cfg_ready;
        if (rst_n)
        begin
            if (cfg_fire)
            begin
                case (cfg_index)
                    REG_WIDTH:  cur_width = cfg_data;
                    REG_HEIGHT: cur_height = cfg_data;
                    default:    ;
                endcase
            end

            if (in_fire)
            begin
                results_due.push_back(rasterize(on_bus));
                accepted_cnt++;
            end

            if (out_fire)
            begin
                got = rast_result_t'(m_tdata[OUT_FIELD_BITS-1:0]);
                if (results_due.size() == 0)
                    note_failure($sformatf("unexpected result read_value=%0d pixels_written=%0d",
                                           got.read_value, got.pixels_written));
                else
                begin
                    want = results_due.pop_front();
                    if (got.read_value !== want.read_value ||
                        got.pixels_written !== want.pixels_written)
                        note_failure($sformatf(
                            "result %0d: read_value exp %0d got %0d, pixels_written exp %0d got %0d",
                            result_cnt, want.read_value, got.read_value,
                            want.pixels_written, got.pixels_written));
                end
                result_cnt++;
            end

            if (in_fire || out_fire || cfg_fire)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                         stall_cycles, results_due.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Stimulus: directed requests at reset size, then random phases at several sizes
    initial
    begin : stim_blk
        int phase_w [NUM_PHASES] = '{1023, 0, 300, 1, 512, 17, 513, -1, 64};
        int phase_h [NUM_PHASES] = '{1023, 300, 0, 1, 512, 9, 40, -1, 512};
        int w, h, span_w, span_h, clear_phase, clear_slot;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: saturation, clipping on every side, extremes, unused code, clear
        queue_item(mk(CMD_READ, 0, 0, 0, 0, 0));
        queue_item(mk(CMD_DRAW, 0, 0, 9, 0, 255));
        queue_item(mk(CMD_DRAW, 0, 0, 9, 0, 1));
        queue_item(mk(CMD_READ, 5, 0, 0, 0, 0));
        queue_item(mk(CMD_DRAW, 3, -5, 3, 5, 7));
        queue_item(mk(CMD_READ, 3, 2, 0, 0, 0));
        queue_item(mk(CMD_READ, 3, 0, 0, 0, 0));
        queue_item(mk(CMD_DRAW, 100, 100, 100, 100, 0));
        queue_item(mk(CMD_DRAW, 329, 409, 320, 380, 200));
        queue_item(mk(CMD_READ, 329, 409, 0, 0, 0));
        queue_item(mk(CMD_DRAW, COORD_LO, COORD_LO, COORD_HI, COORD_HI, 128));
        queue_item(mk(CMD_DRAW, COORD_HI, COORD_LO, COORD_LO, COORD_HI, 255));
        queue_item(mk(CMD_DRAW, 400, 5, 500, 5, 9));
        queue_item(mk(CMD_READ, 330, 0, 0, 0, 0));
        queue_item(mk(CMD_READ, -1, 0, 0, 0, 0));
        queue_item(mk(CMD_READ, 0, 410, 0, 0, 0));
        queue_item(mk(CMD_READ, COORD_HI, COORD_HI, 0, 0, 0));
        queue_item(mk(CMD_READ, COORD_LO, COORD_LO, 0, 0, 0));
        queue_item(mk(CMD_READ, 200, 200, 0, 0, 0));
        queue_item(mk(CMD_UNUSED, -1, -1, -1, -1, 255));
        queue_item(mk(CMD_CLEAR, 0, 0, 0, 0, 0));
        queue_item(mk(CMD_READ, 5, 0, 0, 0, 0));
        queue_item(mk(CMD_DRAW, 0, 0, 5, 3, 255));
        queue_item(mk(CMD_READ, 5, 3, 0, 0, 0));
        wait_drained();

        // Random phases; a single clear lands somewhere since each costs a full sweep
        clear_phase = $urandom_range(0, NUM_PHASES - 1);
        clear_slot = $urandom_range(0, ITEMS_PER_PHASE - 1);
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            w = (phase_w[p] < 0) ? int'($urandom_range(1, 1023)) : phase_w[p];
            h = (phase_h[p] < 0) ? int'($urandom_range(1, 1023)) : phase_h[p];
            set_size(w, h);
            span_w = (w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w;
            span_h = (h > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : h;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (p == clear_phase && i == clear_slot)
                    queue_item(mk(CMD_CLEAR, full_coord(), full_coord(), full_coord(),
                                  full_coord(), rand_intensity()));
                else
                    queue_item(rand_item(span_w, span_h));
            end
            wait_drained();
        end

        // Let any stray result show up before closing
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (results_due.size() != 0)
            note_failure($sformatf("%0d expected results never arrived", results_due.size()));

        $display("Covered %0d draws (%0d pixels plotted), %0d reads (%0d nonzero, %0d at 255),",
                 draws_seen, pixels_plotted, reads_seen, reads_nonzero, reads_full);
        $display("%0d clears, %0d unused codes over %0d size settings; %0d mismatches",
                 clears_seen, unused_seen, size_settings + 1, fail_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
